### hw/rtl/lpmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpmd_pkg
// Shared types for the length-prefixed message deframer.
// ----------------------------------------------------------------------------
package lpmd_pkg;

  // One payload word as it leaves the block.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_of_message;
    logic       last_of_message;
  } lpmd_word_t;

endpackage
`default_nettype wire

### hw/rtl/lpmd_frame_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpmd_frame_core
// Header parser and payload counter; one word per cycle while step_i is high, result is comb.
// ----------------------------------------------------------------------------
module lpmd_frame_core #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic               op_i,
  input  wire logic [7:0]         data_byte_i,
  output logic                    res_valid_o,
  output lpmd_pkg::lpmd_word_t    res_o
);
  import lpmd_pkg::*;

  localparam logic [2:0] PhShortHi = 3'd0;
  localparam logic [2:0] PhShortLo = 3'd1;
  localparam logic [2:0] PhExt0    = 3'd2;
  localparam logic [2:0] PhExt1    = 3'd3;
  localparam logic [2:0] PhExt2    = 3'd4;
  localparam logic [2:0] PhExt3    = 3'd5;
  localparam logic [2:0] PhPayload = 3'd6;

  localparam logic [32:0] MaxLen = (33'd1 << LENGTH_BITS) - 33'd1;

  logic [2:0]             phase_q, phase_d;
  logic [31:0]            gather_q, gather_d;
  logic [LENGTH_BITS-1:0] left_q, left_d;
  logic                   start_q, start_d;

  logic [15:0]            short_len;
  logic [31:0]            ext_len;
  logic [LENGTH_BITS-1:0] ext_sat;
  logic                   last;

  assign short_len = {gather_q[7:0], data_byte_i};
  assign ext_len   = {gather_q[23:0], data_byte_i};
  assign ext_sat   = ({1'b0, ext_len} > MaxLen) ? MaxLen[LENGTH_BITS-1:0]
                                                : ext_len[LENGTH_BITS-1:0];
  assign last      = (left_q <= LENGTH_BITS'(1));

  always_comb begin
    phase_d     = phase_q;
    gather_d    = gather_q;
    left_d      = left_q;
    start_d     = start_q;
    res_valid_o = 1'b0;
    res_o.payload_byte     = data_byte_i;
    res_o.first_of_message = start_q;
    res_o.last_of_message  = last;
    if (op_i) begin
      phase_d  = PhShortHi;
      gather_d = '0;
      left_d   = '0;
      start_d  = 1'b1;
    end else begin
      case (phase_q)
        PhShortLo: begin
          gather_d = '0;
          start_d  = 1'b1;
          if (short_len != 16'd0) begin
            left_d  = LENGTH_BITS'(short_len);
            phase_d = PhPayload;
          end else begin
            phase_d = PhExt0;
          end
        end
        PhExt0, PhExt1, PhExt2: begin
          gather_d = ext_len;
          phase_d  = phase_q + 3'd1;
        end
        PhExt3: begin
          gather_d = '0;
          start_d  = 1'b1;
          if (ext_len == 32'd0) begin
            left_d  = '0;
            phase_d = PhShortHi;
          end else begin
            left_d  = ext_sat;
            phase_d = PhPayload;
          end
        end
        PhPayload: begin
          res_valid_o = step_i;
          start_d     = 1'b0;
          if (last) begin
            phase_d  = PhShortHi;
            gather_d = '0;
            left_d   = '0;
            start_d  = 1'b1;
          end else begin
            left_d = left_q - LENGTH_BITS'(1);
          end
        end
        default: begin
          // short header first byte; unused code lands here too
          gather_d = {24'd0, data_byte_i};
          left_d   = '0;
          phase_d  = PhShortLo;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhShortHi;
      gather_q <= '0;
      left_q   <= '0;
      start_q  <= 1'b1;
    end else if (step_i) begin
      phase_q  <= phase_d;
      gather_q <= gather_d;
      left_q   <= left_d;
      start_q  <= start_d;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lpmd_skid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpmd_skid
// Two-entry output buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module lpmd_skid (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  lpmd_pkg::lpmd_word_t      push_word_i,
  output logic                      space_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output lpmd_pkg::lpmd_word_t      out_word_o
);
  import lpmd_pkg::*;

  logic       out_vld_q, out_vld_d;
  logic       skd_vld_q, skd_vld_d;
  lpmd_word_t out_q, out_d;
  lpmd_word_t skd_q, skd_d;
  logic       pop;

  assign pop         = out_vld_q & out_ready_i;
  assign space_o     = ~skd_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  always_comb begin
    out_vld_d = out_vld_q;
    skd_vld_d = skd_vld_q;
    out_d     = out_q;
    skd_d     = skd_q;
    if (skd_vld_q) begin
      if (pop) begin
        out_d     = skd_q;
        skd_vld_d = 1'b0;
      end
    end else if (!out_vld_q || pop) begin
      out_vld_d = push_i;
      out_d     = push_word_i;
    end else if (push_i) begin
      skd_vld_d = 1'b1;
      skd_d     = push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skd_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      skd_vld_q <= skd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    skd_q <= skd_d;
  end

endmodule
`default_nettype wire

### hw/rtl/length_prefixed_message_deframer.sv
`default_nettype none
// Payload words are registered in the output buffer; header words give no output word.
// Throughput: one input word per cycle while in_ready_o is high.
// The header parser and payload counter update once per accepted word.
// A two-entry output buffer holds one more payload word while the output stalls.
// Reset (rst_ni low, asynchronous): framing returns to the first header byte,
// and the output buffer empties.
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer
// Splits a byte stream into messages with a 16-bit big-endian length,
// or a 32-bit one after a zero short length, and marks payload boundaries.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer #(
  parameter int unsigned LENGTH_BITS = 32  // message length width, 16..32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input words
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       op_i,
  input  wire logic [7:0] data_byte_i,
  // output words
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      payload_byte_o,
  output logic            first_of_message_o,
  output logic            last_of_message_o
);
  import lpmd_pkg::*;

  logic       step;       // input word accepted this cycle
  logic       res_valid;  // accepted word is a payload byte
  lpmd_word_t res_word;
  lpmd_word_t out_word;

  // Ready only depends on the skid entry being free, so a stalled output
  // still lets one more payload word in.
  assign step = in_valid_i & in_ready_o;

  lpmd_frame_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .op_i       (op_i),
    .data_byte_i(data_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res_word)
  );

  lpmd_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_word_i(res_word),
    .space_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word)
  );

  assign payload_byte_o     = out_word.payload_byte;
  assign first_of_message_o = out_word.first_of_message;
  assign last_of_message_o  = out_word.last_of_message;

endmodule
`default_nettype wire
